/* hw/rtl/trapz_pkg.sv */
// trapz_pkg: shared constants, codes and helpers for the trapezoidal integrator.
// Used by trapz_mul, trapz_div, trapezoid_rule_integrator and the testbench; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package trapz_pkg;

  localparam int MAX_TRAPEZOIDS = 4096;
  localparam int FRAC_BITS      = 16;
  localparam int CORDIC_STEPS   = 16;
  localparam int ATAN_LEN       = 24;
  localparam int CORD_ITERS     = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

  localparam int CNT_W      = 13;   // trapezoid count
  localparam int DIV_W      = 33;   // span b - a
  localparam int MUL_A_W    = 34;
  localparam int MUL_B_W    = 48;
  localparam int MUL_DIGIT  = 8;
  localparam int MUL_DIGITS = MUL_B_W / MUL_DIGIT;
  localparam int MUL_P_W    = 82;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_ZERO = 2'd1;
  localparam logic [1:0] STAT_SAT  = 2'd2;

  localparam logic [2:0] ACT_LIN = 3'd0;
  localparam logic [2:0] ACT_SQ  = 3'd1;
  localparam logic [2:0] ACT_CUB = 3'd2;
  localparam logic [2:0] ACT_QRT = 3'd3;
  localparam logic [2:0] ACT_SIN = 3'd4;
  localparam logic [2:0] ACT_COS = 3'd5;

  // 1/(2*pi) in Q32 (2^32 / (2*pi) as an integer), and the CORDIC gain compensation in Q3.30
  localparam logic signed [MUL_B_W-1:0] INV_TWO_PI  = 48'sd683565276;
  localparam logic signed [33:0]        CORDIC_GAIN = 34'sd652032874;

  localparam logic signed [MUL_P_W-1:0] V_MAX = 82'sd2147483647;
  localparam logic signed [MUL_P_W-1:0] V_MIN = -82'sd2147483648;

  typedef struct packed {
    logic signed [31:0] val;
    logic               ovf;
  } sat_t;

  function automatic sat_t sat32(input logic signed [MUL_P_W-1:0] v);
    sat_t r;
    if (v > V_MAX) begin
      r.val = 32'sh7fff_ffff;
      r.ovf = 1'b1;
    end else if (v < V_MIN) begin
      r.val = 32'sh8000_0000;
      r.ovf = 1'b1;
    end else begin
      r.val = v[31:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  // arctangent of 2^-i in binary angle units (2^32 per turn)
  function automatic logic signed [32:0] atan_bam(input logic [4:0] idx);
    logic [31:0] t;
    case (idx)
      5'd0:  t = 32'h2000_0000;
      5'd1:  t = 32'h12E4_051E;
      5'd2:  t = 32'h09FB_385B;
      5'd3:  t = 32'h0511_11D4;
      5'd4:  t = 32'h028B_0D43;
      5'd5:  t = 32'h0145_D7E1;
      5'd6:  t = 32'h00A2_F61E;
      5'd7:  t = 32'h0051_7C55;
      5'd8:  t = 32'h0028_BE53;
      5'd9:  t = 32'h0014_5F2F;
      5'd10: t = 32'h000A_2F98;
      5'd11: t = 32'h0005_17CC;
      5'd12: t = 32'h0002_8BE6;
      5'd13: t = 32'h0001_45F3;
      5'd14: t = 32'h0000_A2FA;
      5'd15: t = 32'h0000_517D;
      5'd16: t = 32'h0000_28BE;
      5'd17: t = 32'h0000_145F;
      5'd18: t = 32'h0000_0A30;
      5'd19: t = 32'h0000_0518;
      5'd20: t = 32'h0000_028C;
      5'd21: t = 32'h0000_0146;
      5'd22: t = 32'h0000_00A3;
      5'd23: t = 32'h0000_0051;
      default: t = 32'h0;
    endcase
    return signed'({1'b0, t});
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/trapz_mul.sv */
// trapz_mul: signed 34 x 48 multiplier, one 8-bit digit of b per cycle.
// Depends on trapz_pkg.
`timescale 1ns / 1ps
`default_nettype none
module trapz_mul (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [trapz_pkg::MUL_A_W-1:0] a,
  input  logic signed [trapz_pkg::MUL_B_W-1:0] b,
  output logic                                 done,
  output logic signed [trapz_pkg::MUL_P_W-1:0] p
);

  logic [trapz_pkg::MUL_A_W-1:0]                      amag;
  logic [trapz_pkg::MUL_B_W-1:0]                      bmag;
  logic [trapz_pkg::MUL_P_W-1:0]                      acc;
  logic                                               neg;
  logic                                               busy;
  logic [2:0]                                         cnt;
  logic [trapz_pkg::MUL_A_W+trapz_pkg::MUL_DIGIT-1:0] pp;

  assign pp = amag * bmag[trapz_pkg::MUL_B_W-1 -: trapz_pkg::MUL_DIGIT];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        amag <= a[trapz_pkg::MUL_A_W-1] ? trapz_pkg::MUL_A_W'(-a) : a;
        bmag <= b[trapz_pkg::MUL_B_W-1] ? trapz_pkg::MUL_B_W'(-b) : b;
        neg  <= a[trapz_pkg::MUL_A_W-1] ^ b[trapz_pkg::MUL_B_W-1];
        acc  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        acc  <= (acc << trapz_pkg::MUL_DIGIT)
              + {{(trapz_pkg::MUL_P_W-trapz_pkg::MUL_A_W-trapz_pkg::MUL_DIGIT){1'b0}}, pp};
        bmag <= bmag << trapz_pkg::MUL_DIGIT;
        cnt  <= cnt + 3'd1;
        if (cnt == 3'(trapz_pkg::MUL_DIGITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign p = neg ? signed'(-acc) : signed'(acc);

endmodule
`default_nettype wire

/* hw/rtl/trapz_div.sv */
// trapz_div: restoring divider, signed span by unsigned count, truncating.
// Depends on trapz_pkg.
`timescale 1ns / 1ps
`default_nettype none
module trapz_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [trapz_pkg::DIV_W-1:0] dividend,
  input  logic        [trapz_pkg::CNT_W-1:0] divisor,
  output logic                               done,
  output logic signed [trapz_pkg::DIV_W:0]   quotient
);

  logic [trapz_pkg::DIV_W-1:0] dq;
  logic [trapz_pkg::CNT_W-1:0] rem;
  logic [trapz_pkg::CNT_W-1:0] dvs;
  logic                        neg;
  logic                        busy;
  logic [5:0]                  cnt;
  logic [trapz_pkg::CNT_W:0]   rem2;
  logic                        ge;
  logic [trapz_pkg::CNT_W:0]   diff;

  assign rem2 = {rem, dq[trapz_pkg::DIV_W-1]};
  assign ge   = rem2 >= {1'b0, dvs};
  assign diff = rem2 - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dq   <= dividend[trapz_pkg::DIV_W-1] ? trapz_pkg::DIV_W'(-dividend) : dividend;
        neg  <= dividend[trapz_pkg::DIV_W-1];
        dvs  <= divisor;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[trapz_pkg::CNT_W-1:0] : rem2[trapz_pkg::CNT_W-1:0];
        dq  <= {dq[trapz_pkg::DIV_W-2:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'(trapz_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? signed'(-{1'b0, dq}) : signed'({1'b0, dq});

endmodule
`default_nettype wire

/* hw/rtl/trapezoid_rule_integrator.sv */
// trapezoid_rule_integrator: composite trapezoidal rule over six fixed functions.
// Depends on trapz_pkg, trapz_mul (shared multiplier) and trapz_div (step divider).
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  req     | req_valid/req_ready  | action, trapezoid_count, interval_start/end
//  res     | res_valid/res_ready  | integral_value, status
//
// Flow: one division for the step h, then per sample (n+1 of them, n the clamped count)
//   the products on the shared multiplier: none for 5x-7, one / two / three for the
//   square, cubic and quartic, and for the sine and cosine the angle product plus
//   16 CORDIC rotations; one final product h * sum / 2 ends the request.
//   A zero count answers in the next cycle. Reset (rst, synchronous) empties the
//   block. req_ready is high only in idle; a waiting result holds until taken.
`timescale 1ns / 1ps
`default_nettype none
module trapezoid_rule_integrator (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [2:0]         action,
  input  logic [12:0]        trapezoid_count,
  input  logic signed [31:0] interval_start,
  input  logic signed [31:0] interval_end,
  output logic               res_valid,
  input  logic               res_ready,
  output logic signed [31:0] integral_value,
  output logic [1:0]         status
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_DIV   = 8'b0000_0010,
    ST_POINT = 8'b0000_0100,
    ST_DISP  = 8'b0000_1000,
    ST_MUL   = 8'b0001_0000,
    ST_CORD  = 8'b0010_0000,
    ST_ACC   = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_t;

  // what the pending product is for
  typedef enum logic [2:0] {
    TAG_X2, TAG_X3, TAG_X4, TAG_ANG, TAG_FIN
  } mtag_t;

  localparam logic signed [33:0] UNIT34 = 34'sd1 <<< trapz_pkg::FRAC_BITS;
  localparam logic signed [39:0] UNIT40 = 40'sd1 <<< trapz_pkg::FRAC_BITS;
  localparam logic signed [31:0] UNIT32 = 32'sd1 <<< trapz_pkg::FRAC_BITS;

  state_t state;
  mtag_t  tag;

  logic [2:0]         act_q;
  logic [12:0]        n_q;
  logic signed [31:0] a_q, b_q;
  logic signed [33:0] h, xrun, x;
  logic [12:0]        pt;
  logic signed [31:0] x2, x3, x4;
  logic signed [33:0] cx, cy;
  logic signed [32:0] z;
  logic [4:0]         k;
  logic               flip;
  logic signed [47:0] total;
  logic               ovf;

  logic                                 mul_start, mul_done;
  logic signed [trapz_pkg::MUL_A_W-1:0] mul_a;
  logic signed [trapz_pkg::MUL_B_W-1:0] mul_b;
  logic signed [trapz_pkg::MUL_P_W-1:0] mul_p;
  logic                                 div_start, div_done;
  logic signed [32:0]                   span;
  logic signed [33:0]                   quot;

  // span b - a, exact in 33 bits
  assign span = {b_q[31], b_q} - {a_q[31], a_q};

  trapz_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  trapz_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (span),
    .divisor  (n_q),
    .done     (div_done),
    .quotient (quot)
  );

  // product rescaled by one unit (fx_mul) and by one unit and a halving (final h * sum / 2)
  trapz_pkg::sat_t s16, s17;
  assign s16 = trapz_pkg::sat32(mul_p >>> trapz_pkg::FRAC_BITS);
  assign s17 = trapz_pkg::sat32(mul_p >>> (trapz_pkg::FRAC_BITS + 1));

  // angle in binary units: low word of floor(x * K / 2^FRAC), folded to +-quarter turn
  logic signed [31:0] ang;
  logic signed [32:0] zf;
  logic               flipf;
  assign ang = mul_p[trapz_pkg::FRAC_BITS +: 32];

  always_comb begin
    flipf = 1'b0;
    zf    = {ang[31], ang};
    if (ang > 32'sd1073741824) begin
      zf    = 33'sd2147483648 - {ang[31], ang};
      flipf = 1'b1;
    end else if (ang < -32'sd1073741824) begin
      zf    = -33'sd2147483648 - {ang[31], ang};
      flipf = 1'b1;
    end
  end

  // one CORDIC rotation
  logic signed [33:0] dx, dy;
  logic signed [32:0] at;
  assign dx = cy >>> k;
  assign dy = cx >>> k;
  assign at = trapz_pkg::atan_bam(k);

  // sample value from the gathered powers or rotation result
  logic signed [39:0] xe, x2e, x3e, x4e, poly;
  logic signed [33:0] sn, cs, csf;
  logic signed [31:0] smp;
  logic               smp_ovf;
  trapz_pkg::sat_t    ps;
  logic               interior;
  logic signed [47:0] total_next;

  assign xe  = {{6{x[33]}}, x};
  assign x2e = {{8{x2[31]}}, x2};
  assign x3e = {{8{x3[31]}}, x3};
  assign x4e = {{8{x4[31]}}, x4};
  assign sn  = cy >>> (30 - trapz_pkg::FRAC_BITS);
  assign cs  = cx >>> (30 - trapz_pkg::FRAC_BITS);
  assign csf = flip ? -cs : cs;

  always_comb begin
    case (act_q)
      trapz_pkg::ACT_LIN: poly = 40'sd5 * xe - 40'sd7 * UNIT40;
      trapz_pkg::ACT_SQ:  poly = 40'sd2 * x2e - 40'sd3 * xe + UNIT40;
      trapz_pkg::ACT_CUB: poly = 40'sd4 * x3e - x2e + 40'sd3 * xe + 40'sd8 * UNIT40;
      trapz_pkg::ACT_QRT: poly = x4e - 40'sd2 * x3e + x2e + 40'sd9 * xe;
      default:            poly = '0;
    endcase
  end

  assign ps = trapz_pkg::sat32({{42{poly[39]}}, poly});

  always_comb begin
    case (act_q)
      trapz_pkg::ACT_LIN, trapz_pkg::ACT_SQ, trapz_pkg::ACT_CUB, trapz_pkg::ACT_QRT: begin
        smp     = ps.val;
        smp_ovf = ps.ovf;
      end
      trapz_pkg::ACT_SIN: begin
        smp     = sn[31:0] + 32'sd3 * UNIT32;
        smp_ovf = 1'b0;
      end
      trapz_pkg::ACT_COS: begin
        smp     = {csf[30:0], 1'b0};
        smp_ovf = 1'b0;
      end
      default: begin
        smp     = '0;
        smp_ovf = 1'b0;
      end
    endcase
  end

  // interior points count twice, the two ends once
  assign interior   = (pt != 13'd0) && (pt != n_q);
  assign total_next = total + (interior ? {{15{smp[31]}}, smp, 1'b0}
                                        : {{16{smp[31]}}, smp});

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mul_start <= 1'b0;
      div_start <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            act_q <= action;
            a_q   <= interval_start;
            b_q   <= interval_end;
            n_q   <= (trapezoid_count > 13'(trapz_pkg::MAX_TRAPEZOIDS))
                   ? 13'(trapz_pkg::MAX_TRAPEZOIDS) : trapezoid_count;
            ovf   <= 1'b0;
            total <= '0;
            pt    <= '0;
            if (trapezoid_count == 13'd0) begin
              integral_value <= '0;
              status         <= trapz_pkg::STAT_ZERO;
              state          <= ST_OUT;
            end else begin
              div_start <= 1'b1;
              state     <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            h     <= quot;
            xrun  <= {{2{a_q[31]}}, a_q} + quot;
            state <= ST_POINT;
          end
        end
        ST_POINT: begin
          if (pt == 13'd0)      x <= {{2{a_q[31]}}, a_q};
          else if (pt == n_q)   x <= {{2{b_q[31]}}, b_q};
          else                  x <= xrun;
          state <= ST_DISP;
        end
        ST_DISP: begin
          case (act_q)
            trapz_pkg::ACT_SQ, trapz_pkg::ACT_CUB, trapz_pkg::ACT_QRT: begin
              mul_a     <= x;
              mul_b     <= {{14{x[33]}}, x};
              mul_start <= 1'b1;
              tag       <= TAG_X2;
              state     <= ST_MUL;
            end
            trapz_pkg::ACT_SIN: begin
              mul_a     <= x;
              mul_b     <= trapz_pkg::INV_TWO_PI;
              mul_start <= 1'b1;
              tag       <= TAG_ANG;
              state     <= ST_MUL;
            end
            trapz_pkg::ACT_COS: begin
              mul_a     <= x - UNIT34;
              mul_b     <= trapz_pkg::INV_TWO_PI;
              mul_start <= 1'b1;
              tag       <= TAG_ANG;
              state     <= ST_MUL;
            end
            default: state <= ST_ACC;
          endcase
        end
        ST_MUL: begin
          if (mul_done) begin
            case (tag)
              TAG_X2: begin
                x2  <= s16.val;
                ovf <= ovf | s16.ovf;
                if (act_q == trapz_pkg::ACT_SQ) begin
                  state <= ST_ACC;
                end else begin
                  mul_a     <= x;
                  mul_b     <= {{16{s16.val[31]}}, s16.val};
                  mul_start <= 1'b1;
                  tag       <= TAG_X3;
                end
              end
              TAG_X3: begin
                x3  <= s16.val;
                ovf <= ovf | s16.ovf;
                if (act_q == trapz_pkg::ACT_CUB) begin
                  state <= ST_ACC;
                end else begin
                  mul_a     <= {{2{x2[31]}}, x2};
                  mul_b     <= {{16{x2[31]}}, x2};
                  mul_start <= 1'b1;
                  tag       <= TAG_X4;
                end
              end
              TAG_X4: begin
                x4    <= s16.val;
                ovf   <= ovf | s16.ovf;
                state <= ST_ACC;
              end
              TAG_ANG: begin
                z     <= zf;
                flip  <= flipf;
                cx    <= trapz_pkg::CORDIC_GAIN;
                cy    <= '0;
                k     <= '0;
                state <= ST_CORD;
              end
              TAG_FIN: begin
                integral_value <= s17.val;
                status <= (ovf | s17.ovf) ? trapz_pkg::STAT_SAT : trapz_pkg::STAT_OK;
                state  <= ST_OUT;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_CORD: begin
          if (!z[32]) begin
            cx <= cx - dx;
            cy <= cy + dy;
            z  <= z - at;
          end else begin
            cx <= cx + dx;
            cy <= cy - dy;
            z  <= z + at;
          end
          k <= k + 5'd1;
          if (k == 5'(trapz_pkg::CORD_ITERS - 1)) state <= ST_ACC;
        end
        ST_ACC: begin
          total <= total_next;
          ovf   <= ovf | smp_ovf;
          if (pt == n_q) begin
            mul_a     <= h;
            mul_b     <= total_next;
            mul_start <= 1'b1;
            tag       <= TAG_FIN;
            state     <= ST_MUL;
          end else begin
            pt <= pt + 13'd1;
            if (pt != 13'd0) xrun <= xrun + h;
            state <= ST_POINT;
          end
        end
        ST_OUT: begin
          if (res_ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign req_ready = (state == ST_IDLE);
  assign res_valid = (state == ST_OUT);

  // sequencer stays on exactly one state
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state not one-hot");

  // a zero count is answered at once with the error status
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && trapezoid_count == 13'd0)
      |=> (res_valid && status == trapz_pkg::STAT_ZERO && integral_value == 32'sd0))
    else $error("zero count not rejected");

  // the point index never runs past the last sample
  a_pt: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POINT || state == ST_ACC || state == ST_DISP) |-> (pt <= n_q))
    else $error("sample index beyond count");

  // the final product only starts from the last accumulation
  a_fin: assert property (@(posedge clk) disable iff (rst)
    (mul_start && tag == TAG_FIN) |-> ($past(state) == ST_ACC && pt == n_q))
    else $error("final product launched early");

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// testbench: self-checking bench for trapezoid_rule_integrator.
// Depends on trapz_pkg and the integrator RTL; predicts each result in a local model.
`timescale 1ns / 1ps
module testbench;

  localparam int UNIT_FX = 1 << trapz_pkg::FRAC_BITS;

  // arctangent of 2^-i in binary angle units
  localparam longint ATAN_TBL [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
    64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         stat;
  } integral_t;

  int mismatches = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Integral predictor: Q16.16 trapezoid sum as the block computes it.
  class integral_scoreboard;
    integral_t pending_q[$];

    static function longint flr(longint v, int s);
      return v >>> s;  // arithmetic shift is floor division by 2^s
    endfunction

    static function longint clamp(longint v, ref bit ovf);
      if (v > 64'sd2147483647) begin ovf = 1; return 64'sd2147483647; end
      if (v < -64'sd2147483648) begin ovf = 1; return -64'sd2147483648; end
      return v;
    endfunction

    static function longint fmul(longint p, longint q, ref bit ovf);
      return clamp(flr(p * q, trapz_pkg::FRAC_BITS), ovf);
    endfunction

    static function void sin_cos(longint ang, output longint sn, output longint cs);
      longint turns, a, cx, cy, z, dx, dy;
      bit flip;
      turns = flr(ang * 64'sd683565276, trapz_pkg::FRAC_BITS);
      a = longint'($signed(turns[31:0]));
      flip = 0;
      if (a > 64'sh40000000) begin a = 64'sh80000000 - a; flip = 1; end
      else if (a < -64'sh40000000) begin a = -64'sh80000000 - a; flip = 1; end
      cx = 64'sd652032874; cy = 0; z = a;
      for (int i = 0; i < trapz_pkg::CORD_ITERS; i++) begin
        dx = flr(cy, i); dy = flr(cx, i);
        if (z >= 0) begin cx -= dx; cy += dy; z -= ATAN_TBL[i]; end
        else begin cx += dx; cy -= dy; z += ATAN_TBL[i]; end
      end
      sn = flr(cy, 30 - trapz_pkg::FRAC_BITS);
      cs = flr(cx, 30 - trapz_pkg::FRAC_BITS);
      if (flip) cs = -cs;
    endfunction

    static function longint eval_fn(logic [2:0] sel, longint x, ref bit ovf);
      longint x2, x3, x4, sn, cs;
      case (sel)
        trapz_pkg::ACT_LIN: return clamp(5 * x - 7 * UNIT_FX, ovf);
        trapz_pkg::ACT_SQ: begin
          x2 = fmul(x, x, ovf);
          return clamp(2 * x2 - 3 * x + UNIT_FX, ovf);
        end
        trapz_pkg::ACT_CUB: begin
          x2 = fmul(x, x, ovf); x3 = fmul(x2, x, ovf);
          return clamp(4 * x3 - x2 + 3 * x + 8 * UNIT_FX, ovf);
        end
        trapz_pkg::ACT_QRT: begin
          x2 = fmul(x, x, ovf); x3 = fmul(x2, x, ovf); x4 = fmul(x2, x2, ovf);
          return clamp(x4 - 2 * x3 + x2 + 9 * x, ovf);
        end
        trapz_pkg::ACT_SIN: begin sin_cos(x, sn, cs); return sn + 3 * UNIT_FX; end
        trapz_pkg::ACT_COS: begin sin_cos(x - UNIT_FX, sn, cs); return 2 * cs; end
        default: return 0;
      endcase
    endfunction

    function void note_request(logic [2:0] sel, logic [12:0] cnt,
                               logic signed [31:0] lo, logic signed [31:0] hi);
      integral_t e;
      longint n, a, b, h, total, ah, at, r;
      bit ovf;
      ovf = 0;
      n = cnt; a = lo; b = hi;
      if (n == 0) begin
        e.value = 0; e.stat = trapz_pkg::STAT_ZERO;
      end else begin
        if (n > trapz_pkg::MAX_TRAPEZOIDS) n = trapz_pkg::MAX_TRAPEZOIDS;
        h = (b - a) / n;
        total = eval_fn(sel, a, ovf) + eval_fn(sel, b, ovf);
        for (longint i = 1; i < n; i++) total += 2 * eval_fn(sel, a + i * h, ovf);
        ah = h < 0 ? -h : h;
        at = total < 0 ? -total : total;
        if (ah != 0 && at > 64'h7fffffffffffffff / ah) begin
          ovf = 1;
          r = ((h < 0) != (total < 0)) ? -64'sd2147483648 : 64'sd2147483647;
        end else r = clamp(flr(h * total, trapz_pkg::FRAC_BITS + 1), ovf);
        e.value = r[31:0];
        e.stat = ovf ? trapz_pkg::STAT_SAT : trapz_pkg::STAT_OK;
      end
      pending_q.push_back(e);
    endfunction

    task check_result(logic signed [31:0] value, logic [1:0] stat);
      integral_t e;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", value, 0);
        return;
      end
      e = pending_q.pop_front();
      if (value !== e.value) report_mismatch("integral_value", value, e.value);
      if (stat !== e.stat) report_mismatch("status", stat, e.stat);
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic req_valid = 0, req_ready, res_valid, res_ready = 0;
  logic [2:0] action = '0;
  logic [12:0] trapezoid_count = '0;
  logic signed [31:0] interval_start = '0, interval_end = '0;
  logic signed [31:0] integral_value;
  logic [1:0] status;

  integral_scoreboard sb = new();
  bit stimulus_done = 0;
  int hold_off = 0;  // long receiver stall requested by the driver

  always #5 clk = ~clk;

  trapezoid_rule_integrator i_dut (
    .clk, .rst, .req_valid, .req_ready, .action, .trapezoid_count,
    .interval_start, .interval_end, .res_valid, .res_ready, .integral_value, .status
  );

  // One request transaction: random gap, then hold until accepted.
  task automatic send_request(logic [2:0] sel, logic [12:0] cnt,
                              logic signed [31:0] lo, logic signed [31:0] hi);
    int gap;
    gap = $urandom_range(0, 7);
    if (gap > 0) begin
      req_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1; action <= sel; trapezoid_count <= cnt;
    interval_start <= lo; interval_end <= hi;
    do @(posedge clk); while (!req_ready);
    sb.note_request(sel, cnt, lo, hi);
    @(negedge clk);
  endtask

  // Small, well-scaled interval: keeps most sums in range.
  function automatic logic signed [31:0] rnd_point();
    return $signed($urandom_range(0, 20 * UNIT_FX)) - 10 * UNIT_FX;
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off > 0) begin
        res_ready <= 0;
        repeat (hold_off) @(negedge clk);
        hold_off = 0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        res_ready <= 0;
        repeat (stall) @(negedge clk);
      end
      res_ready <= 1;
      @(posedge clk);
      if (res_valid) sb.check_result(integral_value, status);
      @(negedge clk);
    end
  end

  initial begin
    logic [12:0] cnt;
    logic [2:0] sel;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: every function, zero count, clamped count, extremes, unused selectors
    for (int s = 0; s < 6; s++) send_request(s[2:0], 4, -2 * UNIT_FX, 3 * UNIT_FX);
    send_request(trapz_pkg::ACT_LIN, 0, 0, UNIT_FX);
    send_request(trapz_pkg::ACT_SQ, 13'h1fff, 0, UNIT_FX);
    send_request(trapz_pkg::ACT_LIN, 1, 32'sh7fffffff, 32'sh80000000);
    send_request(trapz_pkg::ACT_QRT, 2, 32'sh80000000, 32'sh7fffffff);
    send_request(trapz_pkg::ACT_CUB, 3, -1000 * UNIT_FX, 1000 * UNIT_FX);
    send_request(trapz_pkg::ACT_SIN, 5, 32'sh80000000, 32'sh7fffffff);
    send_request(trapz_pkg::ACT_COS, 1, 32'sh7fffffff, 32'sh80000000);
    send_request(3'd6, 3, 0, UNIT_FX);
    send_request(3'd7, 2, -UNIT_FX, UNIT_FX);
    send_request(trapz_pkg::ACT_SQ, 1, 5 * UNIT_FX, -5 * UNIT_FX);
    send_request(trapz_pkg::ACT_LIN, trapz_pkg::MAX_TRAPEZOIDS, 0, 32'sh7fffffff);
    send_request(trapz_pkg::ACT_LIN, 4097, 32'sh80000000, 0);

    // long receiver stall while requests keep arriving
    hold_off = 400;

    for (int k = 0; k < 81; k++) begin
      sel = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                        : 3'($urandom_range(0, 5));
      case ($urandom_range(0, 9))
        0: cnt = 0;
        1: cnt = 13'($urandom());     // any bit pattern, often clamped
        default: cnt = 13'($urandom_range(1, 12));
      endcase
      if ($urandom_range(0, 4) == 0)
        send_request(sel, cnt, $urandom(), $urandom());
      else
        send_request(sel, cnt, rnd_point(), rnd_point());
    end
    req_valid <= 0;
    stimulus_done = 1;
  end

  initial begin
    wait (stimulus_done);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // watchdog: a few large counts on the slowest function set the bound
  initial begin
    #400ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/trapz_pkg.sv
hw/rtl/trapz_mul.sv
hw/rtl/trapz_div.sv
hw/rtl/trapezoid_rule_integrator.sv
tb/sv/testbench.sv
